// ----- sv/xpp_pkg.sv -----
// shared types and constants for the xoshiro256++ generator with splitmix64 seeding
`default_nettype none
package xpp_pkg;

  localparam int unsigned WordW  = 64;
  localparam int unsigned HalfW  = 32;
  localparam int unsigned NumSt  = 4;
  localparam int unsigned IdxW   = 2;

  localparam logic [WordW-1:0] GoldenInc = 64'h9e3779b97f4a7c15;
  localparam logic [WordW-1:0] MixMul1   = 64'hbf58476d1ce4e5b9;
  localparam logic [WordW-1:0] MixMul2   = 64'h94d049bb133111eb;

  localparam int unsigned OutRot  = 23;
  localparam int unsigned StShift = 17;
  localparam int unsigned StRot   = 45;
  localparam int unsigned MixSh1  = 30;
  localparam int unsigned MixSh2  = 27;
  localparam int unsigned MixSh3  = 31;

  localparam logic OpReseed = 1'b0;
  localparam logic OpNext   = 1'b1;

  typedef enum logic [5:0] {
    StIdle = 6'b000001,
    StInc  = 6'b000010,
    StMul0 = 6'b000100,
    StMul1 = 6'b001000,
    StMul2 = 6'b010000,
    StMix  = 6'b100000
  } ctrl_state_e;

  typedef struct packed {
    logic            load_seed;
    logic            ctr_inc;
    logic            mul_en;
    logic            mul_first;
    logic            mul_a_hi;
    logic            mul_b_hi;
    logic            mix;
    logic            pass;
    logic [IdxW-1:0] word_idx;
    logic            gen_next;
  } dp_cmd_t;

endpackage
`default_nettype wire

// ----- sv/xpp_ctrl.sv -----
// sequencer for reseed and next beats, plus the output valid register
`default_nettype none
module xpp_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic            opcode_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output xpp_pkg::dp_cmd_t     cmd_o
);

  xpp_pkg::ctrl_state_e state_q, state_d;
  logic [xpp_pkg::IdxW-1:0] idx_q, idx_d;
  logic pass_q, pass_d;
  logic ov_q, ov_d;
  logic accept;

  assign in_ready_o  = (state_q == xpp_pkg::StIdle) && (!ov_q || out_ready_i);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = ov_q;

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    pass_d  = pass_q;
    cmd_o   = '0;
    cmd_o.pass     = pass_q;
    cmd_o.word_idx = idx_q;
    ov_d = ov_q && !out_ready_i;
    case (state_q)
      xpp_pkg::StIdle: begin
        if (accept) begin
          if (opcode_i == xpp_pkg::OpNext) begin
            cmd_o.gen_next = 1'b1;
            ov_d = 1'b1;
          end else begin
            cmd_o.load_seed = 1'b1;
            idx_d   = '0;
            pass_d  = 1'b0;
            state_d = xpp_pkg::StInc;
          end
        end
      end
      xpp_pkg::StInc: begin
        cmd_o.ctr_inc = 1'b1;
        state_d = xpp_pkg::StMul0;
      end
      xpp_pkg::StMul0: begin
        cmd_o.mul_en    = 1'b1;
        cmd_o.mul_first = 1'b1;
        state_d = xpp_pkg::StMul1;
      end
      xpp_pkg::StMul1: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_a_hi = 1'b1;
        state_d = xpp_pkg::StMul2;
      end
      xpp_pkg::StMul2: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_b_hi = 1'b1;
        state_d = xpp_pkg::StMix;
      end
      xpp_pkg::StMix: begin
        cmd_o.mix = 1'b1;
        if (!pass_q) begin
          pass_d  = 1'b1;
          state_d = xpp_pkg::StMul0;
        end else begin
          pass_d = 1'b0;
          if (idx_q == xpp_pkg::IdxW'(xpp_pkg::NumSt - 1)) begin
            state_d = xpp_pkg::StIdle;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = xpp_pkg::StInc;
          end
        end
      end
      default: begin
        state_d = xpp_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= xpp_pkg::StIdle;
      idx_q   <= '0;
      pass_q  <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      pass_q  <= pass_d;
      ov_q    <= ov_d;
    end
  end

endmodule
`default_nettype wire

// ----- sv/xpp_datapath.sv -----
// generator state, splitmix64 seeding datapath and output word register
`default_nettype none
module xpp_datapath (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire xpp_pkg::dp_cmd_t            cmd_i,
  input  wire logic [xpp_pkg::WordW-1:0]   seed_i,
  output logic      [xpp_pkg::WordW-1:0]   random_word_o
);

  localparam int unsigned W = xpp_pkg::WordW;
  localparam int unsigned H = xpp_pkg::HalfW;

  logic [W-1:0] gen_q [xpp_pkg::NumSt];
  logic [W-1:0] ctr_q, z_q, acc_q, word_q;
  logic [W-1:0] ctr_sum, mul_k, prod, mixed;
  logic [H-1:0] mul_a, mul_b;
  logic [W-1:0] s0, s1, s2, s3, t2, t3, n0, n1, n2, n3, sum03, word;

  assign ctr_sum = ctr_q + xpp_pkg::GoldenInc;

  // first pass multiplies by the first mixer constant, second pass by the other
  assign mul_k = cmd_i.pass ? xpp_pkg::MixMul2 : xpp_pkg::MixMul1;
  assign mul_a = cmd_i.mul_a_hi ? z_q[W-1:H] : z_q[H-1:0];
  assign mul_b = cmd_i.mul_b_hi ? mul_k[W-1:H] : mul_k[H-1:0];
  assign prod  = W'(mul_a) * W'(mul_b);

  assign mixed = cmd_i.pass ? (acc_q ^ (acc_q >> xpp_pkg::MixSh3))
                            : (acc_q ^ (acc_q >> xpp_pkg::MixSh2));

  assign s0 = gen_q[0];
  assign s1 = gen_q[1];
  assign s2 = gen_q[2];
  assign s3 = gen_q[3];
  assign sum03 = s0 + s3;
  assign word  = {sum03[W-1-xpp_pkg::OutRot:0], sum03[W-1:W-xpp_pkg::OutRot]} + s0;
  assign t2 = s2 ^ s0;
  assign t3 = s3 ^ s1;
  assign n1 = s1 ^ t2;
  assign n0 = s0 ^ t3;
  assign n2 = t2 ^ (s1 << xpp_pkg::StShift);
  assign n3 = {t3[W-1-xpp_pkg::StRot:0], t3[W-1:W-xpp_pkg::StRot]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < xpp_pkg::NumSt; i++) begin
        gen_q[i] <= '0;
      end
    end else begin
      if (cmd_i.gen_next) begin
        gen_q[0] <= n0;
        gen_q[1] <= n1;
        gen_q[2] <= n2;
        gen_q[3] <= n3;
      end else if (cmd_i.mix && cmd_i.pass) begin
        gen_q[cmd_i.word_idx] <= mixed;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_seed) begin
      ctr_q <= seed_i;
    end else if (cmd_i.ctr_inc) begin
      ctr_q <= ctr_sum;
    end
    if (cmd_i.ctr_inc) begin
      z_q <= ctr_sum ^ (ctr_sum >> xpp_pkg::MixSh1);
    end else if (cmd_i.mix && !cmd_i.pass) begin
      z_q <= mixed;
    end
    // low product first, then the two cross terms land in the upper half
    if (cmd_i.mul_en) begin
      if (cmd_i.mul_first) begin
        acc_q <= prod;
      end else begin
        acc_q <= acc_q + {prod[H-1:0], {H{1'b0}}};
      end
    end
    if (cmd_i.gen_next) begin
      word_q <= word;
    end
  end

  assign random_word_o = word_q;

endmodule
`default_nettype wire

// ----- sv/xoshiro256pp_prng_with_seeding_top.sv -----
// top level of the xoshiro256++ generator with splitmix64 seeding
// input channel: in_valid_i/in_ready_o with opcode_i and seed_i; a beat with
//   opcode 0 reseeds from seed_i, a beat with opcode 1 asks for a random word
// output channel: out_valid_o/out_ready_i with random_word_o, one beat per
//   next request and none for a reseed
// next: the word appears in the output register on the cycle
//   after acceptance, and next beats stream at one per cycle while the
//   receiver keeps taking them
// reseed: the next beat is taken only once all four state words are built,
//   each from one counter step plus two 64-bit multiplies done as three 32x32
//   partial products on one shared multiplier, each followed by a xor-shift step
// stall: a held output word blocks a new input beat only when the receiver
//   is not taking it in the same cycle; the word stays unchanged meanwhile
// reset: the state is cleared to zero, so a next before any reseed gives
//   zero; no output beat is pending after reset
`default_nettype none
module xoshiro256pp_prng_with_seeding_top (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic                      opcode_i,
  input  wire logic [xpp_pkg::WordW-1:0] seed_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic      [xpp_pkg::WordW-1:0] random_word_o
);

  xpp_pkg::dp_cmd_t cmd;

  xpp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .opcode_i    (opcode_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  xpp_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .seed_i        (seed_i),
    .random_word_o (random_word_o)
  );

endmodule
`default_nettype wire
